### rtl/frms_pkg.sv
// frms_pkg: constants, sequencer states and control structs for frame_rms.
// Depends on nothing; every other file of the block imports it.

package frms_pkg;

   // Field widths of the channels
   localparam int SAMPLE_W = 16;
   localparam int RMS_W    = 16;
   localparam int LEN_W    = 11;

   // Frame and sample limits
   localparam int MAX_FRAME   = 1024;
   localparam int SAMPLE_BITS = 16;

   // Derived datapath widths
   localparam int COUNT_W = $clog2(MAX_FRAME + 1);
   localparam int SQ_W    = 2 * SAMPLE_BITS;
   localparam int SUM_W   = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FRAME);
   localparam int RT_W    = SAMPLE_BITS;
   localparam int RAD_W   = 2 * RT_W;
   localparam int DREM_W  = COUNT_W + 1;
   localparam int ALU_W   = (DREM_W > RT_W + 3) ? DREM_W : RT_W + 3;
   localparam int STEP_W  = $clog2(SUM_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_LOAD,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } seq_state_type;

   // Commands from the sequencer to the accumulator
   typedef struct packed {
      logic take;    // capture the square of the incoming sample
      logic add;     // fold the captured square into the running sum
      logic clear;   // start a new frame
   } acc_cmd_type;

endpackage

### rtl/frms_req_if.sv
// frms_req_if: sample channel of frame_rms (valid/ready plus payload).
// Depends on frms_pkg.

interface frms_req_if;
   import frms_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

### rtl/frms_rsp_if.sv
// frms_rsp_if: result channel of frame_rms (valid/ready plus payload).
// Depends on frms_pkg.

interface frms_rsp_if;
   import frms_pkg::*;

   logic             valid;
   logic             ready;
   logic [RMS_W-1:0] rms_value;
   logic             frame_too_long;
   logic [LEN_W-1:0] frame_length;

   modport source (output valid, output rms_value, output frame_too_long,
                   output frame_length, input ready);
   modport sink   (input valid, input rms_value, input frame_too_long,
                   input frame_length, output ready);
endinterface

### rtl/frms_alu.sv
// frms_alu: shared compare-and-subtract unit, used by the divider and the
// square root steps. Depends on frms_pkg.

module frms_alu (
   input  logic [frms_pkg::ALU_W-1:0] minuend,
   input  logic [frms_pkg::ALU_W-1:0] subtrahend,
   output logic                       ge,
   output logic [frms_pkg::ALU_W-1:0] diff
);
   import frms_pkg::*;

   logic [ALU_W:0] wide_diff;

   assign wide_diff = {1'b0, minuend} - {1'b0, subtrahend};
   assign ge        = ~wide_diff[ALU_W];
   assign diff      = wide_diff[ALU_W-1:0];
endmodule

### rtl/frms_acc.sv
// frms_acc: squares samples and keeps the frame's sum of squares, sample
// count and overflow mark. Depends on frms_pkg.

module frms_acc (
   input  logic                          clock,
   input  logic                          reset,
   input  frms_pkg::acc_cmd_type         cmd,
   input  logic [frms_pkg::SAMPLE_W-1:0] sample,
   output logic [frms_pkg::SUM_W-1:0]    sum,
   output logic [frms_pkg::COUNT_W-1:0]  count,
   output logic                          overflow
);
   import frms_pkg::*;

   logic [SAMPLE_BITS-1:0] raw;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SQ_W-1:0]        square_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   overflow_ff;
   logic                   full;

   // Only the low sample bits count; the magnitude of the most negative
   // value wraps to its own pattern, which is still the right unsigned value.
   assign raw  = sample[SAMPLE_BITS-1:0];
   assign mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
   assign full = (count_ff >= COUNT_W'(MAX_FRAME));

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         square_ff <= SQ_W'(mag) * SQ_W'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         sum_ff      <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.add) begin
         if (full) begin
            overflow_ff <= 1'b1;
         end else begin
            sum_ff   <= sum_ff + SUM_W'(square_ff);
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   assign sum      = sum_ff;
   assign count    = count_ff;
   assign overflow = overflow_ff;
endmodule

### rtl/frame_rms.sv
// frame_rms: RMS over a frame of Q2.13 samples, one shared subtractor.
// A last sample's result is offered after the add, load, SUM_W = 41 divide steps,
// RT_W = 16 root steps and done states; other samples give none. Inside a frame
// a sample is accepted and then accumulated before the next is taken; after a last
// sample the next waits for the whole divide and root, longer while rsp stalls.
// Reset (synchronous) clears the frame state, the sequencer and rsp valid.

module frame_rms (
   input  logic       clock,
   input  logic       reset,
   frms_req_if.sink   req_chan,
   frms_rsp_if.source rsp_chan
);
   import frms_pkg::*;

   seq_state_type       state_ff;
   seq_state_type       state_in;
   acc_cmd_type         acc_cmd;

   logic [SUM_W-1:0]    acc_sum;
   logic [COUNT_W-1:0]  acc_count;
   logic                acc_overflow;

   logic                last_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [COUNT_W-1:0]  div_ff;      // divisor: frame length
   logic [ALU_W-1:0]    rem_ff;      // partial remainder of divide or root
   logic [SUM_W-1:0]    work_ff;     // dividend -> quotient -> radicand
   logic [RT_W-1:0]     root_ff;
   logic [COUNT_W-1:0]  len_ff;
   logic                ovf_ff;

   logic                rsp_valid_ff;
   logic [RMS_W-1:0]    rms_ff;
   logic                too_long_ff;
   logic [LEN_W-1:0]    length_ff;

   logic [ALU_W-1:0]    alu_a;
   logic [ALU_W-1:0]    alu_b;
   logic                alu_ge;
   logic [ALU_W-1:0]    alu_diff;

   logic                accept;
   logic                step_last;
   logic                rsp_free;

   assign accept    = req_chan.valid && req_chan.ready;
   assign step_last = (step_ff == '0);
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   frms_acc u_acc (
      .clock    (clock),
      .reset    (reset),
      .cmd      (acc_cmd),
      .sample   (req_chan.sample),
      .sum      (acc_sum),
      .count    (acc_count),
      .overflow (acc_overflow)
   );

   frms_alu u_alu (
      .minuend    (alu_a),
      .subtrahend (alu_b),
      .ge         (alu_ge),
      .diff       (alu_diff)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = last_ff ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_last) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (step_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            // Wait here only while the previous result is still unclaimed
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: handshake, accumulator commands, shared unit operands
   always_comb begin
      req_chan.ready = 1'b0;
      acc_cmd        = '0;
      alu_a          = '0;
      alu_b          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            acc_cmd.take   = req_chan.valid;
         end
         ST_ADD: begin
            acc_cmd.add = 1'b1;
         end
         ST_LOAD: begin
            acc_cmd.clear = 1'b1;
         end
         ST_DIV: begin
            // Restoring divide: shift in the next dividend bit, try subtract
            alu_a = ALU_W'({rem_ff[COUNT_W-1:0], work_ff[SUM_W-1]});
            alu_b = ALU_W'(div_ff);
         end
         ST_SQRT: begin
            // Digit-by-digit root: bring down two bits, try 4*root + 1
            alu_a = {rem_ff[ALU_W-3:0], work_ff[RAD_W-1 -: 2]};
            alu_b = ALU_W'({root_ff, 2'b01});
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath of the divide and root iterations
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) last_ff <= req_chan.last_sample;
         end
         ST_LOAD: begin
            // Snapshot the frame; the accumulator clears in the same cycle
            div_ff  <= acc_count;
            len_ff  <= acc_count;
            ovf_ff  <= acc_overflow;
            work_ff <= acc_sum;
            rem_ff  <= '0;
            step_ff <= STEP_W'(SUM_W - 1);
         end
         ST_DIV: begin
            work_ff <= {work_ff[SUM_W-2:0], alu_ge};
            if (step_last) begin
               rem_ff  <= '0;
               root_ff <= '0;
               step_ff <= STEP_W'(RT_W - 1);
            end else begin
               rem_ff  <= alu_ge ? alu_diff : alu_a;
               step_ff <= step_ff - 1'b1;
            end
         end
         ST_SQRT: begin
            rem_ff  <= alu_ge ? alu_diff : alu_a;
            root_ff <= {root_ff[RT_W-2:0], alu_ge};
            work_ff <= work_ff << 2;
            step_ff <= step_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Result register: holds a finished transaction while the sink stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rms_ff      <= RMS_W'(root_ff);
         too_long_ff <= ovf_ff;
         length_ff   <= LEN_W'(len_ff);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.rms_value      = rms_ff;
   assign rsp_chan.frame_too_long = too_long_ff;
   assign rsp_chan.frame_length   = length_ff;
endmodule

### rtl/frms_checker.sv
// frms_checker: port-level assertions for frame_rms, attached by bind.
// Depends on frms_pkg and on the top level's channel ports.

module frms_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [frms_pkg::RMS_W-1:0] rms_value,
   input logic                       frame_too_long,
   input logic [frms_pkg::LEN_W-1:0] frame_length
);
   import frms_pkg::*;

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rms_value))
      else $error("frame_rms: stalled result changed");

   // One transaction at a time: ready drops right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("frame_rms: ready stayed high after accept");

   // Every frame holds at least its last sample
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> frame_length != '0)
      else $error("frame_rms: empty frame reported");

   // Overflow only on a saturated count, and the root stays in range
   a_overflow_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_too_long |-> frame_length == LEN_W'(MAX_FRAME))
      else $error("frame_rms: too-long flag without saturated length");

   a_rms_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rms_value <= RMS_W'(2 ** (SAMPLE_BITS - 1)))
      else $error("frame_rms: rms out of range");
endmodule

bind frame_rms frms_checker u_frms_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rms_value      (rsp_chan.rms_value),
   .frame_too_long (rsp_chan.frame_too_long),
   .frame_length   (rsp_chan.frame_length)
);

### tb/tb_frame_rms.sv
// tb_frame_rms: self-checking testbench for frame_rms, RMS over frames of Q2.13 samples.
// Depends on frms_pkg, frms_req_if and frms_rsp_if from rtl, and on the frame_rms top.

module tb_frame_rms;
   import frms_pkg::*;

   // Watchdog limit in clock cycles.
   localparam int CYCLE_LIMIT   = 400000;
   // Cycles to keep watching after the last expected result has arrived.
   localparam int DRAIN_CYCLES  = 100;
   // Length of the one long receiver hold-off.
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 150;

   // Track the frame in progress and queue the result each closed frame must produce.
   class rms_tracker;
      typedef struct packed {
         logic [RMS_W-1:0] rms;
         logic             too_long;
         logic [LEN_W-1:0] len;
      } frame_result_type;

      bit [SUM_W-1:0]    sq_sum;
      bit [LEN_W-1:0]    n_samples;
      bit                overflow;
      frame_result_type  expected_frames[$];
      int                errors;

      // Floor square root, one result bit at a time from the top.
      function bit [RMS_W-1:0] floor_root(bit [63:0] v);
         bit [RMS_W:0] r;
         bit [RMS_W:0] trial;
         r = '0;
         for (int b = RMS_W; b >= 0; b--) begin
            trial = r | ((RMS_W+1)'(1) << b);
            if (64'(trial) * 64'(trial) <= v)
               r = trial;
         end
         return r[RMS_W-1:0];
      endfunction

      // Fold one accepted sample into the frame; close the frame on last.
      function void take_sample(logic [SAMPLE_W-1:0] s, logic last);
         bit [SAMPLE_W-1:0] mag;
         bit [63:0]         mean;
         frame_result_type  r;
         mag = s[SAMPLE_W-1] ? -s : s;
         if (n_samples >= LEN_W'(MAX_FRAME)) begin
            overflow = 1'b1;
         end else begin
            sq_sum    = sq_sum + SUM_W'(64'(mag) * 64'(mag));
            n_samples = n_samples + 1'b1;
         end
         if (!last)
            return;
         mean       = 64'(sq_sum) / 64'(n_samples);
         r.rms      = floor_root(mean);
         r.too_long = overflow;
         r.len      = n_samples;
         expected_frames.push_back(r);
         sq_sum    = '0;
         n_samples = '0;
         overflow  = 1'b0;
      endfunction

      function void check_frame(logic [RMS_W-1:0] rms, logic too_long, logic [LEN_W-1:0] len);
         frame_result_type e;
         if (expected_frames.size() == 0) begin
            $error("result transaction with no frame pending: rms_value %0d", rms);
            errors++;
            return;
         end
         e = expected_frames.pop_front();
         if (rms !== e.rms) begin
            $error("rms_value: expected %0d, actual %0d", e.rms, rms);
            errors++;
         end
         if (too_long !== e.too_long) begin
            $error("frame_too_long: expected %0d, actual %0d", e.too_long, too_long);
            errors++;
         end
         if (len !== e.len) begin
            $error("frame_length: expected %0d, actual %0d", e.len, len);
            errors++;
         end
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   frms_req_if req();
   frms_rsp_if rsp();

   frame_rms uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   rms_tracker tracker = new();

   // Sender burst state and the one-shot request for the long receiver hold-off.
   int burst_left;
   int samples_sent;
   bit hold_off_req;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Drive every input to a known value from time zero.
   initial begin
      reset           = 1'b1;
      req.valid       = 1'b0;
      req.sample      = '0;
      req.last_sample = 1'b0;
      rsp.ready       = 1'b0;
      hold_off_req    = 1'b0;
      burst_left      = 0;
      samples_sent    = 0;
   end

   // Monitor: note accepted samples first, then check any accepted result. Both are
   // sampled at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid === 1'b1 && req.ready === 1'b1)
            tracker.take_sample(req.sample, req.last_sample);
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            tracker.check_frame(rsp.rms_value, rsp.frame_too_long, rsp.frame_length);
      end
   end

   // Receiver: pick a new stall pattern for each window; serve one long hold-off when
   // the stimulus asks for it, counting the cycles here.
   initial begin
      int hold_left;
      int window_left;
      int stall_mode;
      hold_left   = 0;
      window_left = 0;
      stall_mode  = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (window_left == 0) begin
            stall_mode  = $urandom_range(0, 3);
            window_left = 64;
         end
         window_left--;
         if (hold_left == 0 && hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp.ready <= 1'b1;                              // no stalls at all
               1: rsp.ready <= ($urandom_range(0, 1) == 1);       // coin flip
               2: rsp.ready <= ($urandom_range(0, 3) == 0);       // mostly stalled
               default: rsp.ready <= ($urandom_range(0, 7) != 0); // rare stalls
            endcase
         end
      end
   end

   // Offer one sample and hold it until the block takes it. Between bursts, drop valid
   // for a random gap; some bursts are long and gapless.
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic last);
      int gap;
      @(negedge clock);
      req.valid       <= 1'b1;
      req.sample      <= s;
      req.last_sample <= last;
      do @(posedge clock); while (req.ready !== 1'b1);
      samples_sent++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(40, 120);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(0, 6);
         end
         if (gap > 0) begin
            @(negedge clock);
            req.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Pick a sample: often full range, with small magnitudes and extremes mixed in.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: s = SAMPLE_W'($urandom_range(0, 65535));
         4, 5:       s = SAMPLE_W'($urandom_range(0, 255)) ^ {SAMPLE_W{$urandom_range(0, 1) == 1}};
         6:          s = 16'h8000;
         7:          s = 16'h7FFF;
         8:          s = ($urandom_range(0, 1) == 1) ? 16'h8001 : 16'hFFFF;
         default:    s = '0;
      endcase
      return s;
   endfunction

   // Send a frame of n random samples, the last one marked.
   task automatic send_frame(input int n);
      for (int i = 0; i < n; i++)
         send_sample(pick_sample(), i == n - 1);
   endtask

   // Stimulus and end of run.
   initial begin
      int frame_len;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: one-sample frames at zero and both extremes.
      send_sample(16'h0000, 1'b1);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h0001, 1'b1);
      // Frame of most negative samples only: rms of exactly 32768.
      send_sample(16'h8000, 1'b0);
      send_sample(16'h8000, 1'b1);
      // Mixed signs and alternating bit patterns.
      send_sample(16'h0001, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'h8001, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h5555, 1'b0);
      send_sample(16'hAAAA, 1'b1);
      send_sample(16'hFFFE, 1'b0);
      send_sample(16'h0003, 1'b0);
      send_sample(16'h0064, 1'b0);
      send_sample(16'hFF9C, 1'b0);
      send_sample(16'h03E8, 1'b1);

      // Overlong frame of most negative samples: the sum sets its top bit, the count
      // saturates, and the marked sample past MAX_FRAME is dropped as the flag rises.
      for (int i = 0; i < MAX_FRAME; i++)
         send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b1);

      // Random frames, mostly short. Ask the receiver for its long hold-off right away
      // so the block fills up while samples keep coming.
      hold_off_req = 1'b1;
      samples_sent = 0;
      while (samples_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:                   frame_len = $urandom_range(41, 120);
            1, 2, 3, 4, 5:       frame_len = $urandom_range(7, 40);
            default:             frame_len = $urandom_range(1, 6);
         endcase
         send_frame(frame_len);
      end
      @(negedge clock);
      req.valid <= 1'b0;

      // Wait for every frame result, then watch a while for stray transactions.
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.errors == 0)
         $display("** frame_rms: PASSED **");
      else
         $display("** frame_rms: FAILED **");
      $finish;
   end

   // Watchdog: end the run if it hangs.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("** frame_rms: FAILED **");
      $finish;
   end

endmodule
